// ===== sv/ldmc_pkg.sv =====
package ldmc_pkg;

    // Level and register widths
    localparam int LEVEL_BITS = 12;
    localparam int REG_W      = 12;
    localparam int REQ_W      = 16;
    localparam int APB_AW     = 5;
    localparam logic [REQ_W-1:0] LEVEL_MAX = REQ_W'((32'd1 << LEVEL_BITS) - 32'd1);

    // Event codes
    localparam logic [3:0] OP_TICK    = 4'd0;
    localparam logic [3:0] OP_SET     = 4'd1;
    localparam logic [3:0] OP_ENABLE  = 4'd2;
    localparam logic [3:0] OP_DISABLE = 4'd3;
    localparam logic [3:0] OP_PSAVE   = 4'd4;
    localparam logic [3:0] OP_SHUT    = 4'd5;
    localparam logic [3:0] OP_AUTO    = 4'd6;
    localparam logic [3:0] OP_LIGHT   = 4'd7;
    localparam logic [3:0] OP_IRRIG   = 4'd8;

    // Mode codes
    localparam logic [1:0] MODE_DISABLED = 2'd0;
    localparam logic [1:0] MODE_ENABLED  = 2'd1;
    localparam logic [1:0] MODE_SHUTDOWN = 2'd2;

    // Bus action codes
    localparam logic [1:0] BUS_NONE    = 2'd0;
    localparam logic [1:0] BUS_REQUEST = 2'd1;
    localparam logic [1:0] BUS_RELEASE = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_PWRFAIL = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_PSAVE_LIMIT = 3'd0;
    localparam logic [2:0] REG_MAX_LEVEL   = 3'd1;
    localparam logic [2:0] REG_MIN_LEVEL   = 3'd2;
    localparam logic [2:0] REG_RAMP_STEP   = 3'd3;
    localparam logic [2:0] REG_DARK_ON     = 3'd4;
    localparam logic [2:0] REG_BRIGHT_OFF  = 3'd5;

    // Register reset values
    localparam logic [REG_W-1:0] RST_PSAVE_LIMIT = 12'd512;
    localparam logic [REG_W-1:0] RST_MAX_LEVEL   = 12'd4095;
    localparam logic [REG_W-1:0] RST_MIN_LEVEL   = 12'd205;
    localparam logic [REG_W-1:0] RST_RAMP_STEP   = 12'd41;
    localparam logic [REG_W-1:0] RST_DARK_ON     = 12'd400;
    localparam logic [REG_W-1:0] RST_BRIGHT_OFF  = 12'd300;

    typedef struct packed {
        logic [REG_W-1:0] psave_limit;
        logic [REG_W-1:0] max_level;
        logic [REG_W-1:0] min_level;
        logic [REG_W-1:0] ramp_step;
        logic [REG_W-1:0] dark_on_mv;
        logic [REG_W-1:0] bright_off_mv;
    } t_cfg;

    typedef struct packed {
        logic [1:0]       mode;
        logic [REG_W-1:0] duty;
        logic [REG_W-1:0] goal;
        logic [REQ_W-1:0] user_pref;
        logic [REQ_W-1:0] auto_pref;
        logic             driver_on;
        logic             auto_active;
        logic             save_active;
        logic             irrig_active;
        logic [REG_W-1:0] last_light;
        logic [1:0]       saved_mode;
        logic [REQ_W-1:0] saved_pref;
        logic             saved_save;
    } t_state;

    typedef struct packed {
        logic [3:0]       op;
        logic [REQ_W-1:0] level_request;
        logic             flag;
        logic [REG_W-1:0] light_mv;
        logic             power_granted;
    } t_event;

    typedef struct packed {
        logic [REG_W-1:0] duty;
        logic [REG_W-1:0] goal_level;
        logic [1:0]       mode;
        logic             lights_on;
        logic [1:0]       bus_action;
        logic [1:0]       status;
    } t_result;

endpackage

// ===== sv/ldmc_in_if.sv =====
interface ldmc_in_if;
    import ldmc_pkg::*;

    logic             valid;
    logic             ready;
    logic [3:0]       op;
    logic [REQ_W-1:0] level_request;
    logic             flag;
    logic [REG_W-1:0] light_mv;
    logic             power_granted;

    modport source (output valid, op, level_request, flag, light_mv, power_granted,
                    input ready);
    modport sink   (input valid, op, level_request, flag, light_mv, power_granted,
                    output ready);
endinterface

// ===== sv/ldmc_out_if.sv =====
interface ldmc_out_if;
    import ldmc_pkg::*;

    logic             valid;
    logic             ready;
    logic [REG_W-1:0] duty;
    logic [REG_W-1:0] goal_level;
    logic [1:0]       mode;
    logic             lights_on;
    logic [1:0]       bus_action;
    logic [1:0]       status;

    modport source (output valid, duty, goal_level, mode, lights_on, bus_action, status,
                    input ready);
    modport sink   (input valid, duty, goal_level, mode, lights_on, bus_action, status,
                    output ready);
endinterface

// ===== sv/ldmc_event_logic.sv =====
module ldmc_event_logic (
    input  ldmc_pkg::t_state  i_state,
    input  ldmc_pkg::t_cfg    i_cfg,
    input  ldmc_pkg::t_event  i_evt,
    output ldmc_pkg::t_state  o_state,
    output ldmc_pkg::t_result o_result
);
    import ldmc_pkg::*;

    // Working set: state plus this beat's side-band codes
    typedef struct packed {
        t_state     s;
        logic [1:0] bus;
        logic [1:0] status;
    } t_work;

    function automatic logic [REQ_W-1:0] sat_level(input logic [REQ_W-1:0] x);
        sat_level = (x > LEVEL_MAX) ? LEVEL_MAX : x;
    endfunction

    // Clamp order: mode, power-save limit, max, then up to min if nonzero
    function automatic logic [REG_W-1:0] clamp_level(input logic [REQ_W-1:0] x,
                                                     input t_state s, input t_cfg c);
        logic [REQ_W-1:0] v;
        v = x;
        if (s.mode != MODE_ENABLED) begin
            v = '0;
        end else begin
            if (s.save_active && v > REQ_W'(c.psave_limit)) v = REQ_W'(c.psave_limit);
            if (v > REQ_W'(c.max_level)) v = REQ_W'(c.max_level);
            if (v != '0 && v < REQ_W'(c.min_level)) v = REQ_W'(c.min_level);
        end
        clamp_level = REG_W'(sat_level(v));
    endfunction

    function automatic logic [REG_W-1:0] effective_goal(input t_state s, input t_cfg c);
        logic [REG_W-1:0] t;
        t = clamp_level(s.user_pref, s, c);
        if (s.irrig_active && t != '0) t = REG_W'(sat_level(REQ_W'(c.min_level)));
        effective_goal = t;
    endfunction

    function automatic t_work lights_on(input t_work w, input logic granted, input t_cfg c);
        t_work r;
        r = w;
        r.bus = BUS_REQUEST;
        if (!granted) begin
            r.status = ST_PWRFAIL;
        end else begin
            r.s.driver_on = 1'b1;
            if (!r.s.irrig_active) r.s.goal = effective_goal(r.s, c);
        end
        lights_on = r;
    endfunction

    function automatic t_work lights_off(input t_work w);
        t_work r;
        r = w;
        r.s.driver_on = 1'b0;
        r.s.goal      = '0;
        r.bus         = BUS_RELEASE;
        lights_off = r;
    endfunction

    t_work            w;
    logic [REG_W-1:0] diff;
    logic             want;

    // Ramp distance between duty and goal, and the light-reading on/off decision
    always_comb begin
        diff = (i_state.duty < i_state.goal) ? (i_state.goal - i_state.duty)
                                             : (i_state.duty - i_state.goal);
        want = i_state.driver_on ? (i_evt.light_mv >= i_cfg.bright_off_mv)
                                 : (i_evt.light_mv > i_cfg.dark_on_mv);
    end

    // Event decode and state update
    always_comb begin
        w.s      = i_state;
        w.bus    = BUS_NONE;
        w.status = ST_OK;
        unique case (i_evt.op)
            OP_TICK: begin
                if (i_state.duty != i_state.goal) begin
                    if (diff < i_cfg.ramp_step)            w.s.duty = i_state.goal;
                    else if (i_state.duty < i_state.goal)  w.s.duty = i_state.duty + i_cfg.ramp_step;
                    else                                   w.s.duty = i_state.duty - i_cfg.ramp_step;
                end
            end
            OP_SET: begin
                w.s.user_pref = i_evt.level_request;
                if (i_state.auto_active && i_evt.level_request != '0)
                    w.s.auto_pref = i_evt.level_request;
                if (!i_state.irrig_active) w.s.goal = effective_goal(w.s, i_cfg);
            end
            OP_ENABLE: begin
                if (i_state.mode != MODE_ENABLED) begin
                    w.s.mode = MODE_ENABLED;
                    if (!i_state.auto_active || i_state.last_light > i_cfg.dark_on_mv)
                        w = lights_on(w, i_evt.power_granted, i_cfg);
                end
            end
            OP_DISABLE: begin
                w = lights_off(w);
                w.s.mode = MODE_DISABLED;
            end
            OP_PSAVE: begin
                if (i_evt.flag != i_state.save_active) begin
                    w.s.save_active = i_evt.flag;
                    if (i_evt.flag) begin
                        if (i_state.user_pref > REQ_W'(i_cfg.psave_limit))
                            w.s.user_pref = REQ_W'(i_cfg.psave_limit);
                    end else if (i_state.user_pref > REQ_W'(i_cfg.max_level)) begin
                        w.s.user_pref = REQ_W'(i_cfg.max_level);
                    end
                    if (!i_state.irrig_active && i_state.mode == MODE_ENABLED)
                        w.s.goal = effective_goal(w.s, i_cfg);
                end
            end
            OP_SHUT: begin
                if (i_evt.flag) begin
                    w.s.saved_mode = i_state.mode;
                    w.s.saved_pref = i_state.user_pref;
                    w.s.saved_save = i_state.save_active;
                    w.s.mode       = MODE_SHUTDOWN;
                    w = lights_off(w);
                end else begin
                    w.s.mode        = i_state.saved_mode;
                    w.s.user_pref   = i_state.saved_pref;
                    w.s.save_active = i_state.saved_save;
                    if (i_state.saved_mode == MODE_ENABLED)
                        w = lights_on(w, i_evt.power_granted, i_cfg);
                end
            end
            OP_AUTO: begin
                if (i_evt.flag) begin
                    w.s.auto_active = 1'b1;
                    if (i_state.mode == MODE_ENABLED) begin
                        if (i_state.last_light > i_cfg.dark_on_mv) begin
                            if (!i_state.driver_on) w = lights_on(w, i_evt.power_granted, i_cfg);
                        end else if (i_state.driver_on) begin
                            w = lights_off(w);
                        end
                    end
                end else begin
                    w.s.auto_active = 1'b0;
                    if (i_state.mode == MODE_ENABLED && !i_state.driver_on)
                        w.s.mode = MODE_DISABLED;
                end
            end
            OP_LIGHT: begin
                if (!i_state.auto_active) begin
                    w.status = ST_INVALID;
                end else begin
                    w.s.last_light = i_evt.light_mv;
                    if (i_state.mode == MODE_ENABLED) begin
                        if (want && !i_state.driver_on)
                            w = lights_on(w, i_evt.power_granted, i_cfg);
                        else if (!want && i_state.driver_on)
                            w = lights_off(w);
                    end
                end
            end
            OP_IRRIG: begin
                if (i_evt.flag && !i_state.irrig_active) begin
                    w.s.irrig_active = 1'b1;
                    w.s.goal = REG_W'(sat_level(REQ_W'(i_cfg.min_level)));
                end else if (!i_evt.flag && i_state.irrig_active) begin
                    w.s.irrig_active = 1'b0;
                    if (i_state.auto_active && i_state.mode == MODE_ENABLED) begin
                        if (i_state.last_light > i_cfg.dark_on_mv) begin
                            if (!i_state.driver_on)
                                w = lights_on(w, i_evt.power_granted, i_cfg);
                            else
                                w.s.goal = clamp_level(i_state.auto_pref, w.s, i_cfg);
                        end else if (i_state.driver_on) begin
                            w = lights_off(w);
                        end
                    end else begin
                        w.s.goal = effective_goal(w.s, i_cfg);
                    end
                end
            end
            default: begin
                // unused op codes leave everything as is
            end
        endcase
    end

    assign o_state             = w.s;
    assign o_result.duty       = w.s.duty;
    assign o_result.goal_level = w.s.goal;
    assign o_result.mode       = w.s.mode;
    assign o_result.lights_on  = w.s.driver_on;
    assign o_result.bus_action = w.bus;
    assign o_result.status     = w.status;

endmodule

// ===== sv/led_dimmer_mode_controller_top.sv =====
// Channel   Dir  Handshake      Beat contents
// i_in      in   valid/ready    op, level_request, flag, light_mv, power_granted
// o_out     out  valid/ready    duty, goal_level, mode, lights_on, bus_action, status
// APB       in   psel/penable   six 12-bit registers at byte offsets 0x00..0x14
//
// Each event is decoded and the state updated at the accepting edge, and the
// result lands in the output register at that same edge.
// A new event is taken every cycle unless the output register holds an untaken beat.
// i_rst_n is synchronous, active low; it restores state and registers to reset values.
// A stall on o_out holds the result and backpressures i_in; no beat is lost.
module led_dimmer_mode_controller_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    ldmc_in_if.sink                    i_in,
    ldmc_out_if.source                 o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ldmc_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import ldmc_pkg::*;

    t_cfg       r_cfg;
    t_state     r_state;
    t_state     n_state;
    t_result    r_res;
    t_result    n_res;
    t_event     evt;
    logic       r_out_valid;
    logic       in_fire;
    logic       cfg_wr;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.psave_limit   <= RST_PSAVE_LIMIT;
            r_cfg.max_level     <= RST_MAX_LEVEL;
            r_cfg.min_level     <= RST_MIN_LEVEL;
            r_cfg.ramp_step     <= RST_RAMP_STEP;
            r_cfg.dark_on_mv    <= RST_DARK_ON;
            r_cfg.bright_off_mv <= RST_BRIGHT_OFF;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_PSAVE_LIMIT: r_cfg.psave_limit   <= pwdata[REG_W-1:0];
                REG_MAX_LEVEL:   r_cfg.max_level     <= pwdata[REG_W-1:0];
                REG_MIN_LEVEL:   r_cfg.min_level     <= pwdata[REG_W-1:0];
                REG_RAMP_STEP:   r_cfg.ramp_step     <= pwdata[REG_W-1:0];
                REG_DARK_ON:     r_cfg.dark_on_mv    <= pwdata[REG_W-1:0];
                REG_BRIGHT_OFF:  r_cfg.bright_off_mv <= pwdata[REG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register readback
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_PSAVE_LIMIT: prdata = 32'(r_cfg.psave_limit);
            REG_MAX_LEVEL:   prdata = 32'(r_cfg.max_level);
            REG_MIN_LEVEL:   prdata = 32'(r_cfg.min_level);
            REG_RAMP_STEP:   prdata = 32'(r_cfg.ramp_step);
            REG_DARK_ON:     prdata = 32'(r_cfg.dark_on_mv);
            REG_BRIGHT_OFF:  prdata = 32'(r_cfg.bright_off_mv);
            default:         prdata = '0;
        endcase
    end

    // Input beat
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;

    assign evt.op            = i_in.op;
    assign evt.level_request = i_in.level_request;
    assign evt.flag          = i_in.flag;
    assign evt.light_mv      = i_in.light_mv;
    assign evt.power_granted = i_in.power_granted;

    ldmc_event_logic u_logic (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_evt    (evt),
        .o_state  (n_state),
        .o_result (n_res)
    );

    // Controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode         <= MODE_DISABLED;
            r_state.duty         <= '0;
            r_state.goal         <= '0;
            r_state.user_pref    <= '0;
            r_state.auto_pref    <= REQ_W'(RST_PSAVE_LIMIT);
            r_state.driver_on    <= 1'b0;
            r_state.auto_active  <= 1'b0;
            r_state.save_active  <= 1'b0;
            r_state.irrig_active <= 1'b0;
            r_state.last_light   <= '0;
            r_state.saved_mode   <= MODE_DISABLED;
            r_state.saved_pref   <= '0;
            r_state.saved_save   <= 1'b0;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) r_res <= n_res;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.duty       = r_res.duty;
    assign o_out.goal_level = r_res.goal_level;
    assign o_out.mode       = r_res.mode;
    assign o_out.lights_on  = r_res.lights_on;
    assign o_out.bus_action = r_res.bus_action;
    assign o_out.status     = r_res.status;

endmodule

// ===== sv/ldmc_checker.sv =====
module ldmc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_bus_action,
    input logic [1:0] i_status
);
    import ldmc_pkg::*;

    // A result beat waiting on the sink stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // Every accepted event yields a result on the next cycle
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("accepted event produced no result");

    // An empty output register never backpressures
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output register");

    // A failed power request always comes with a bus request
    a_fail_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_PWRFAIL |-> i_bus_action == BUS_REQUEST)
        else $error("power failure status without matching request");

endmodule

bind led_dimmer_mode_controller_top ldmc_checker u_ldmc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_bus_action (o_out.bus_action),
    .i_status     (o_out.status)
);

// ===== verif/led_dimmer_mode_controller_top_tb.sv =====
`timescale 1ns / 1ps

module led_dimmer_mode_controller_top_tb;
    import ldmc_pkg::*;

    localparam int          CYCLE_LIMIT     = 400000;
    localparam int          DRAIN_CYCLES    = 4;
    localparam logic [3:0]  OP_FIRST_UNUSED = OP_IRRIG + 4'd1;
    localparam logic [3:0]  OP_LAST_UNUSED  = 4'hF;

    logic i_clk = 1'b0;
    logic i_rst_n;

    // APB side
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    ldmc_in_if  in_if ();
    ldmc_out_if out_if ();

    led_dimmer_mode_controller_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 i_clk = ~i_clk;

    // Shadow of the dimmer: registers, state and per-beat side outputs
    t_cfg       dim_cfg;
    t_state     dim_st;
    logic [1:0] pred_bus;
    logic [1:0] pred_status;

    t_event  dimmer_events_q[$];
    t_result dimmer_results_q[$];

    bit stim_go   = 1'b0;
    bit idle_on   = 1'b0;
    int in_issued   = 0;
    int in_accepted = 0;
    int out_seen    = 0;
    int src_gap     = 0;
    int snk_stall   = 0;
    int cycle_cnt   = 0;
    int fail_cnt    = 0;

    task automatic log_failure(input string msg);
        if (fail_cnt < 10)
            $display("%s", msg);
        fail_cnt++;
    endtask

    // ---------------------------------------------------------------
    // Dimmer prediction
    // ---------------------------------------------------------------

    // enabled-only, power save ceiling, max, then min floor for nonzero
    function automatic logic [REG_W-1:0] clamp_level_req(input logic [REQ_W-1:0] x);
        logic [REQ_W-1:0] v;
        v = x;
        if (dim_st.mode != MODE_ENABLED)
            return '0;
        if (dim_st.save_active && v > dim_cfg.psave_limit)
            v = REQ_W'(dim_cfg.psave_limit);
        if (v > dim_cfg.max_level)
            v = REQ_W'(dim_cfg.max_level);
        if (v != 0 && v < dim_cfg.min_level)
            v = REQ_W'(dim_cfg.min_level);
        return (v > LEVEL_MAX) ? LEVEL_MAX[REG_W-1:0] : v[REG_W-1:0];
    endfunction

    function automatic logic [REG_W-1:0] target_level();
        logic [REG_W-1:0] t;
        t = clamp_level_req(dim_st.user_pref);
        if (dim_st.irrig_active && t != 0)
            t = dim_cfg.min_level;
        return t;
    endfunction

    function automatic void power_lights_on(input logic granted);
        pred_bus = BUS_REQUEST;
        if (!granted) begin
            pred_status = ST_PWRFAIL;
        end else begin
            dim_st.driver_on = 1'b1;
            if (!dim_st.irrig_active)
                dim_st.goal = target_level();
        end
    endfunction

    function automatic void power_lights_off();
        dim_st.driver_on = 1'b0;
        dim_st.goal      = '0;
        pred_bus         = BUS_RELEASE;
    endfunction

    function automatic t_result dimmer_predict(input t_event ev);
        t_result          r;
        logic [REG_W-1:0] diff;
        logic             want;
        pred_bus    = BUS_NONE;
        pred_status = ST_OK;
        case (ev.op)
            OP_TICK: begin
                if (dim_st.duty != dim_st.goal) begin
                    diff = (dim_st.duty < dim_st.goal) ? dim_st.goal - dim_st.duty
                                                       : dim_st.duty - dim_st.goal;
                    if (diff < dim_cfg.ramp_step)
                        dim_st.duty = dim_st.goal;
                    else if (dim_st.duty < dim_st.goal)
                        dim_st.duty = dim_st.duty + dim_cfg.ramp_step;
                    else
                        dim_st.duty = dim_st.duty - dim_cfg.ramp_step;
                end
            end
            OP_SET: begin
                dim_st.user_pref = ev.level_request;
                if (dim_st.auto_active && ev.level_request != 0)
                    dim_st.auto_pref = ev.level_request;
                if (!dim_st.irrig_active)
                    dim_st.goal = target_level();
            end
            OP_ENABLE: begin
                if (dim_st.mode != MODE_ENABLED) begin
                    dim_st.mode = MODE_ENABLED;
                    if (!dim_st.auto_active || dim_st.last_light > dim_cfg.dark_on_mv)
                        power_lights_on(ev.power_granted);
                end
            end
            OP_DISABLE: begin
                power_lights_off();
                dim_st.mode = MODE_DISABLED;
            end
            OP_PSAVE: begin
                if (ev.flag != dim_st.save_active) begin
                    dim_st.save_active = ev.flag;
                    if (ev.flag) begin
                        if (dim_st.user_pref > dim_cfg.psave_limit)
                            dim_st.user_pref = REQ_W'(dim_cfg.psave_limit);
                    end else if (dim_st.user_pref > dim_cfg.max_level) begin
                        dim_st.user_pref = REQ_W'(dim_cfg.max_level);
                    end
                    if (!dim_st.irrig_active && dim_st.mode == MODE_ENABLED)
                        dim_st.goal = target_level();
                end
            end
            OP_SHUT: begin
                if (ev.flag) begin
                    dim_st.saved_mode = dim_st.mode;
                    dim_st.saved_pref = dim_st.user_pref;
                    dim_st.saved_save = dim_st.save_active;
                    dim_st.mode       = MODE_SHUTDOWN;
                    power_lights_off();
                end else begin
                    dim_st.mode        = dim_st.saved_mode;
                    dim_st.user_pref   = dim_st.saved_pref;
                    dim_st.save_active = dim_st.saved_save;
                    if (dim_st.saved_mode == MODE_ENABLED)
                        power_lights_on(ev.power_granted);
                end
            end
            OP_AUTO: begin
                if (ev.flag) begin
                    dim_st.auto_active = 1'b1;
                    if (dim_st.mode == MODE_ENABLED) begin
                        if (dim_st.last_light > dim_cfg.dark_on_mv) begin
                            if (!dim_st.driver_on)
                                power_lights_on(ev.power_granted);
                        end else if (dim_st.driver_on) begin
                            power_lights_off();
                        end
                    end
                end else begin
                    dim_st.auto_active = 1'b0;
                    if (dim_st.mode == MODE_ENABLED && !dim_st.driver_on)
                        dim_st.mode = MODE_DISABLED;
                end
            end
            OP_LIGHT: begin
                if (!dim_st.auto_active) begin
                    pred_status = ST_INVALID;
                end else begin
                    dim_st.last_light = ev.light_mv;
                    if (dim_st.mode == MODE_ENABLED) begin
                        // hysteresis: lit lights use the lower threshold
                        want = dim_st.driver_on ? (ev.light_mv >= dim_cfg.bright_off_mv)
                                                : (ev.light_mv > dim_cfg.dark_on_mv);
                        if (want && !dim_st.driver_on)
                            power_lights_on(ev.power_granted);
                        else if (!want && dim_st.driver_on)
                            power_lights_off();
                    end
                end
            end
            OP_IRRIG: begin
                if (ev.flag && !dim_st.irrig_active) begin
                    dim_st.irrig_active = 1'b1;
                    dim_st.goal         = dim_cfg.min_level;
                end else if (!ev.flag && dim_st.irrig_active) begin
                    dim_st.irrig_active = 1'b0;
                    if (dim_st.auto_active && dim_st.mode == MODE_ENABLED) begin
                        if (dim_st.last_light > dim_cfg.dark_on_mv) begin
                            if (!dim_st.driver_on)
                                power_lights_on(ev.power_granted);
                            else
                                dim_st.goal = clamp_level_req(dim_st.auto_pref);
                        end else if (dim_st.driver_on) begin
                            power_lights_off();
                        end
                    end else begin
                        dim_st.goal = target_level();
                    end
                end
            end
            default: begin
            end
        endcase
        r.duty       = dim_st.duty;
        r.goal_level = dim_st.goal;
        r.mode       = dim_st.mode;
        r.lights_on  = dim_st.driver_on;
        r.bus_action = pred_bus;
        r.status     = pred_status;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus generation
    // ---------------------------------------------------------------

    function automatic t_event rand_event();
        t_event ev;
        int     r;
        r = $urandom_range(0, 99);
        if (r < 28)      ev.op = OP_TICK;
        else if (r < 44) ev.op = OP_SET;
        else if (r < 52) ev.op = OP_ENABLE;
        else if (r < 56) ev.op = OP_DISABLE;
        else if (r < 62) ev.op = OP_PSAVE;
        else if (r < 67) ev.op = OP_SHUT;
        else if (r < 74) ev.op = OP_AUTO;
        else if (r < 90) ev.op = OP_LIGHT;
        else if (r < 97) ev.op = OP_IRRIG;
        else             ev.op = 4'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
        case ($urandom_range(0, 6))
            0:       ev.level_request = '0;
            1:       ev.level_request = REQ_W'($urandom_range(1, 4));
            2:       ev.level_request = REQ_W'($urandom_range(0, 4095));
            3:       ev.level_request = REQ_W'($urandom);
            4:       ev.level_request = '1;
            5:       ev.level_request = REQ_W'(dim_cfg.min_level) + REQ_W'($urandom_range(0, 2))
                                        - REQ_W'(1);
            default: ev.level_request = REQ_W'(dim_cfg.psave_limit) + REQ_W'($urandom_range(0, 2))
                                        - REQ_W'(1);
        endcase
        // readings near either threshold exercise the hysteresis edges
        case ($urandom_range(0, 3))
            0:       ev.light_mv = dim_cfg.dark_on_mv + REG_W'($urandom_range(0, 4)) - REG_W'(2);
            1:       ev.light_mv = dim_cfg.bright_off_mv + REG_W'($urandom_range(0, 4))
                                   - REG_W'(2);
            default: ev.light_mv = REG_W'($urandom_range(0, 4095));
        endcase
        ev.flag          = 1'($urandom_range(0, 1));
        ev.power_granted = ($urandom_range(0, 4) != 0);
        return ev;
    endfunction

    task automatic queue_event(input logic [3:0] op, input logic [REQ_W-1:0] req,
                               input logic fl, input logic [REG_W-1:0] lt, input logic gr);
        t_event ev;
        ev.op            = op;
        ev.level_request = req;
        ev.flag          = fl;
        ev.light_mv      = lt;
        ev.power_granted = gr;
        dimmer_events_q.push_back(ev);
    endtask

    // APB write: setup, access, register taken at the access edge with pready
    task automatic cfg_write(input logic [2:0] idx, input logic [REG_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_PSAVE_LIMIT: dim_cfg.psave_limit   = val;
            REG_MAX_LEVEL:   dim_cfg.max_level     = val;
            REG_MIN_LEVEL:   dim_cfg.min_level     = val;
            REG_RAMP_STEP:   dim_cfg.ramp_step     = val;
            REG_DARK_ON:     dim_cfg.dark_on_mv    = val;
            REG_BRIGHT_OFF:  dim_cfg.bright_off_mv = val;
            default: begin
            end
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_idle();
        while (dimmer_events_q.size() != 0 || in_issued != in_accepted ||
               dimmer_results_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic program_all(input t_cfg c);
        cfg_write(REG_PSAVE_LIMIT, c.psave_limit);
        cfg_write(REG_MAX_LEVEL,   c.max_level);
        cfg_write(REG_MIN_LEVEL,   c.min_level);
        cfg_write(REG_RAMP_STEP,   c.ramp_step);
        cfg_write(REG_DARK_ON,     c.dark_on_mv);
        cfg_write(REG_BRIGHT_OFF,  c.bright_off_mv);
    endtask

    // ---------------------------------------------------------------
    // Input driver: one beat at a time, random idle bursts between beats
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin : drv
        t_event ev;
        if (!stim_go) begin
            in_if.valid <= 1'b0;
        end else if (in_issued != in_accepted) begin
            // beat still waiting for ready: hold it
        end else begin
            if (src_gap == 0 && idle_on && $urandom_range(0, 5) == 0)
                src_gap = $urandom_range(1, 16);
            if (src_gap > 0 || dimmer_events_q.size() == 0) begin
                in_if.valid <= 1'b0;
                if (src_gap > 0)
                    src_gap--;
            end else begin
                ev = dimmer_events_q.pop_front();
                in_if.op            <= ev.op;
                in_if.level_request <= ev.level_request;
                in_if.flag          <= ev.flag;
                in_if.light_mv      <= ev.light_mv;
                in_if.power_granted <= ev.power_granted;
                in_if.valid         <= 1'b1;
                in_issued++;
            end
        end
    end

    // Output backpressure in random bursts
    always @(negedge i_clk) begin
        if (snk_stall == 0 && idle_on && $urandom_range(0, 5) == 0)
            snk_stall = $urandom_range(1, 16);
        if (snk_stall > 0) begin
            out_if.ready <= 1'b0;
            snk_stall--;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: check result beats, predict on accepted input beats
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : mon
        t_result got;
        t_result want;
        t_event  ev;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("DONE: errors detected");
            $finish;
        end else if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                got.duty       = out_if.duty;
                got.goal_level = out_if.goal_level;
                got.mode       = out_if.mode;
                got.lights_on  = out_if.lights_on;
                got.bus_action = out_if.bus_action;
                got.status     = out_if.status;
                if (dimmer_results_q.size() == 0) begin
                    log_failure($sformatf("result beat %0d with no event pending", out_seen));
                end else begin
                    want = dimmer_results_q.pop_front();
                    if (got !== want)
                        log_failure($sformatf({"beat %0d mismatch: exp duty=%0d goal=%0d ",
                            "mode=%0d on=%0d bus=%0d st=%0d | got duty=%0d goal=%0d ",
                            "mode=%0d on=%0d bus=%0d st=%0d"}, out_seen,
                            want.duty, want.goal_level, want.mode, want.lights_on,
                            want.bus_action, want.status,
                            got.duty, got.goal_level, got.mode, got.lights_on,
                            got.bus_action, got.status));
                end
                out_seen++;
            end
            if (in_if.valid && in_if.ready) begin
                ev.op            = in_if.op;
                ev.level_request = in_if.level_request;
                ev.flag          = in_if.flag;
                ev.light_mv      = in_if.light_mv;
                ev.power_granted = in_if.power_granted;
                dimmer_results_q.push_back(dimmer_predict(ev));
                in_accepted++;
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequencer: reset, directed events, then randomized phases
    // ---------------------------------------------------------------
    initial begin : seq
        t_cfg   c;
        t_event ev;
        int     n_items;
        int     cnt;
        int     k;

        i_rst_n             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.op            = OP_TICK;
        in_if.level_request = '0;
        in_if.flag          = 1'b0;
        in_if.light_mv      = '0;
        in_if.power_granted = 1'b0;
        out_if.ready        = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        dim_cfg.psave_limit   = RST_PSAVE_LIMIT;
        dim_cfg.max_level     = RST_MAX_LEVEL;
        dim_cfg.min_level     = RST_MIN_LEVEL;
        dim_cfg.ramp_step     = RST_RAMP_STEP;
        dim_cfg.dark_on_mv    = RST_DARK_ON;
        dim_cfg.bright_off_mv = RST_BRIGHT_OFF;
        dim_st              = '0;
        dim_st.mode         = MODE_DISABLED;
        dim_st.saved_mode   = MODE_DISABLED;
        dim_st.auto_pref    = REQ_W'(RST_PSAVE_LIMIT);

        idle_on = 1'b1;
        stim_go = 1'b1;

        // directed pass at reset settings
        queue_event(OP_SHUT,    16'd0,     1'b0, 12'd0,    1'b1); // restore, no prior shutdown
        queue_event(OP_LIGHT,   16'd0,     1'b0, 12'hFFF,  1'b1); // reading outside auto
        queue_event(OP_SET,     16'hFFFF,  1'b0, 12'd0,    1'b1); // wide request, disabled
        queue_event(OP_ENABLE,  16'd0,     1'b0, 12'd0,    1'b0); // power request refused
        queue_event(OP_DISABLE, 16'd0,     1'b0, 12'd0,    1'b1);
        queue_event(OP_ENABLE,  16'd0,     1'b0, 12'd0,    1'b1); // saturates at max
        queue_event(OP_TICK,    16'd0,     1'b0, 12'd0,    1'b0);
        queue_event(OP_ENABLE,  16'd0,     1'b1, 12'd0,    1'b0); // already enabled
        queue_event(OP_PSAVE,   16'd0,     1'b1, 12'd0,    1'b1);
        queue_event(OP_PSAVE,   16'd0,     1'b1, 12'd0,    1'b1); // no flag change
        queue_event(OP_SET,     16'd1,     1'b0, 12'd0,    1'b1); // floor to min
        queue_event(OP_SET,     16'd0,     1'b0, 12'd0,    1'b1);
        queue_event(OP_IRRIG,   16'd0,     1'b1, 12'd0,    1'b1);
        queue_event(OP_IRRIG,   16'd0,     1'b0, 12'd0,    1'b1);
        queue_event(OP_SHUT,    16'd0,     1'b1, 12'd0,    1'b1);
        queue_event(OP_SHUT,    16'd0,     1'b1, 12'd0,    1'b1); // shutdown while shut down
        queue_event(OP_SHUT,    16'd0,     1'b0, 12'd0,    1'b1);
        queue_event(OP_DISABLE, 16'd0,     1'b0, 12'd0,    1'b1);
        queue_event(OP_IRRIG,   16'd0,     1'b1, 12'd0,    1'b1); // dims with lights off
        queue_event(OP_AUTO,    16'd0,     1'b1, 12'd0,    1'b1);
        queue_event(OP_ENABLE,  16'd0,     1'b0, 12'd0,    1'b1); // auto, still bright
        queue_event(OP_LIGHT,   16'd0,     1'b0, 12'hFFF,  1'b1); // dark: lights on
        queue_event(OP_LIGHT,   16'd0,     1'b0, 12'd350,  1'b1); // inside hysteresis band
        queue_event(OP_LIGHT,   16'd0,     1'b0, 12'd0,    1'b1); // bright: lights off
        queue_event(OP_AUTO,    16'd0,     1'b1, 12'd0,    1'b1); // auto again re-evaluates
        queue_event(OP_AUTO,    16'd0,     1'b0, 12'd0,    1'b1);
        queue_event(OP_FIRST_UNUSED, 16'hFFFF, 1'b1, 12'hFFF, 1'b1);
        queue_event(OP_LAST_UNUSED,  16'hFFFF, 1'b1, 12'hFFF, 1'b1);
        wait_idle();

        // phase 0: everything at full scale, 1: everything zero (ramp stalls),
        // then random settings; the last phase runs without idling
        for (int ph = 0; ph < 9; ph++) begin
            if (ph == 0) begin
                c = '1;
            end else if (ph == 1) begin
                c = '0;
            end else begin
                c.psave_limit   = REG_W'($urandom_range(0, 4095));
                c.max_level     = REG_W'($urandom_range(0, 4095));
                c.min_level     = REG_W'($urandom_range(0, 1023));
                c.ramp_step     = ($urandom_range(0, 4) == 0) ? REG_W'($urandom_range(1, 4095))
                                                              : REG_W'($urandom_range(1, 600));
                c.dark_on_mv    = REG_W'($urandom_range(0, 4095));
                c.bright_off_mv = REG_W'($urandom_range(0, 4095));
            end
            program_all(c);
            idle_on = (ph != 8) && ($urandom_range(0, 3) != 0);
            n_items = (ph < 2) ? 60 : 130;
            cnt = 0;
            while (cnt < n_items) begin
                if ($urandom_range(0, 3) == 0) begin
                    // enable, set a level, then ramp toward it
                    ev = rand_event();
                    ev.op = OP_ENABLE;
                    dimmer_events_q.push_back(ev);
                    ev = rand_event();
                    ev.op = OP_SET;
                    dimmer_events_q.push_back(ev);
                    k = $urandom_range(3, 12);
                    repeat (k) begin
                        ev = rand_event();
                        ev.op = OP_TICK;
                        dimmer_events_q.push_back(ev);
                    end
                    cnt += k + 2;
                end else begin
                    dimmer_events_q.push_back(rand_event());
                    cnt++;
                end
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (dimmer_results_q.size() != 0)
            log_failure($sformatf("%0d results never arrived", dimmer_results_q.size()));
        if (fail_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
